[rtl/des_pkg.sv]
// DES permutation tables, S-boxes and round helpers shared by the cipher modules.
package des_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned CdW    = 56;
  localparam int unsigned SubW   = 28;
  localparam int unsigned RkW    = 48;
  localparam int unsigned NumRounds = 16;

  typedef logic [7:0] pos_t;

  localparam pos_t IP_TAB [64] = '{
    8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
    8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
    8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

  localparam pos_t FP_TAB [64] = '{
    8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
    8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
    8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
    8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

  localparam pos_t EXP_TAB [48] = '{
    8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,
    8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,
    8'd23,8'd24,8'd25,8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

  localparam pos_t PBOX_TAB [32] = '{
    8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
    8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

  localparam pos_t PC1_TAB [56] = '{
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
    8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
    8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
    8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

  localparam pos_t PC2_TAB [48] = '{
    8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,8'd23,8'd19,8'd12,8'd4,
    8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,
    8'd51,8'd45,8'd33,8'd48,8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,
    8'd32};

  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  function automatic logic [BlockW-1:0] perm_ip(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_fp(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
    return r;
  endfunction

  function automatic logic [CdW-1:0] perm_pc1(input logic [KeyW-1:0] v);
    logic [CdW-1:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
    return r;
  endfunction

  function automatic logic [RkW-1:0] perm_pc2(input logic [CdW-1:0] v);
    logic [RkW-1:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
    return r;
  endfunction

  function automatic logic [SubW-1:0] rot28(input logic [SubW-1:0] v, input logic [1:0] s);
    logic [SubW-1:0] r;
    if (s == 2'd1) r = {v[SubW-2:0], v[SubW-1]};
    else r = {v[SubW-3:0], v[SubW-1:SubW-2]};
    return r;
  endfunction

  function automatic logic [HalfW-1:0] feistel(input logic [HalfW-1:0] r,
                                               input logic [RkW-1:0] rk);
    logic [RkW-1:0] x;
    logic [HalfW-1:0] s;
    logic [HalfW-1:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(EXP_TAB[i])];
    x = x ^ rk;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(PBOX_TAB[i])];
    return p;
  endfunction

endpackage

[rtl/des_round_cell.sv]
// One DES round cell: Feistel round on the block and key schedule step, registered.
module des_round_cell #(
  parameter logic [1:0] Rot = 2'd1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [des_pkg::BlockW-1:0]  lr_i,
  input  logic [des_pkg::CdW-1:0]     cd_i,
  output logic                        vld_o,
  output logic [des_pkg::BlockW-1:0]  lr_o,
  output logic [des_pkg::CdW-1:0]     cd_o
);
  logic                        vld_q;
  logic [des_pkg::BlockW-1:0]  lr_q, lr_d;
  logic [des_pkg::CdW-1:0]     cd_q, cd_d;
  logic [des_pkg::RkW-1:0]     rk;

  always_comb begin
    cd_d = {des_pkg::rot28(cd_i[55:28], Rot), des_pkg::rot28(cd_i[27:0], Rot)};
    rk   = des_pkg::perm_pc2(cd_d);
    lr_d = {lr_i[31:0], lr_i[63:32] ^ des_pkg::feistel(lr_i[31:0], rk)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q <= lr_d;
    cd_q <= cd_d;
  end

  assign vld_o = vld_q;
  assign lr_o  = lr_q;
  assign cd_o  = cd_q;
endmodule

[rtl/des_block_encrypt.sv]
// DES encryption top level: key register, chain of sixteen round cells, output permutation.
//
//  channel  | signals                       | direction
//  request  | start_i, busy_o, plain_block_i | in
//  result   | done_o, cipher_block_o         | out
//  config   | cfg_we_i, cfg_key_i            | in
//
// One block enters per cycle; busy_o stays low. The result shows after the
// request has passed the register of each round cell. Each cell carries its
// own key schedule copy, so a key write affects requests taken after it.
// Reset clears the key and the valid chain. The receiver cannot stall.
module des_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] plain_block_i,
  output logic        done_o,
  output logic [63:0] cipher_block_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_key_i
);
  localparam int unsigned N = des_pkg::NumRounds;

  logic [des_pkg::KeyW-1:0]   key_q;
  logic [N:0]                 vld;
  logic [des_pkg::BlockW-1:0] lr [N+1];
  logic [des_pkg::CdW-1:0]    cd [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_key_i;
    end
  end

  assign busy_o = 1'b0;
  assign vld[0] = start_i;
  assign lr[0]  = des_pkg::perm_ip(plain_block_i);
  assign cd[0]  = des_pkg::perm_pc1(key_q);

  for (genvar g = 0; g < N; g++) begin : g_cell
    des_round_cell #(.Rot(des_pkg::ROT_TAB[g])) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (vld[g]),
      .lr_i  (lr[g]),
      .cd_i  (cd[g]),
      .vld_o (vld[g+1]),
      .lr_o  (lr[g+1]),
      .cd_o  (cd[g+1])
    );
  end

  assign done_o         = vld[N];
  assign cipher_block_o = des_pkg::perm_fp({lr[N][31:0], lr[N][63:32]});
endmodule
